/* src/rsde_pkg.sv */
// Package for the instruction executor with DRAM row-buffer timing.
// Holds action and status codes, register indexes, timing defaults and shared structs.
// No dependencies.
`default_nettype none
package rsde_pkg;

   localparam logic [3:0] ACT_ADD  = 4'd0;
   localparam logic [3:0] ACT_ADDI = 4'd1;
   localparam logic [3:0] ACT_SUB  = 4'd2;
   localparam logic [3:0] ACT_MUL  = 4'd3;
   localparam logic [3:0] ACT_J    = 4'd4;
   localparam logic [3:0] ACT_BEQ  = 4'd5;
   localparam logic [3:0] ACT_BNE  = 4'd6;
   localparam logic [3:0] ACT_SLT  = 4'd7;
   localparam logic [3:0] ACT_LW   = 4'd8;
   localparam logic [3:0] ACT_SW   = 4'd9;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_WORD_LIM  = 3'd1;
   localparam logic [2:0] ST_UNWRITTEN = 3'd2;
   localparam logic [2:0] ST_MISALIGN  = 3'd3;
   localparam logic [2:0] ST_MEM_OVF   = 3'd4;
   localparam logic [2:0] ST_BAD_TGT   = 3'd5;

   localparam logic [1:0] CSR_ROW_DELAY = 2'd0;
   localparam logic [1:0] CSR_COL_DELAY = 2'd1;

   localparam logic [9:0] ROW_DELAY_RESET = 10'd10;
   localparam logic [9:0] COL_DELAY_RESET = 10'd2;

   localparam int ROW_BYTES = 1024;
   localparam int ROW_SHIFT = $clog2(ROW_BYTES);
   localparam int LINE_LIMIT = 65536;

   localparam logic [5:0] NO_REG = 6'd63;

   typedef struct packed {
      logic        en;
      logic [4:0]  idx;
      logic [31:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic s1_valid;
      logic hold;
   } exec_ctl_type;

endpackage
`default_nettype wire

/* src/risc_subset_executor_dram_timing_top.sv */
// Top level of the instruction executor with DRAM row-buffer timing.
// Instantiates rsde_regfile, rsde_dmem and rsde_exec; uses rsde_pkg.
//
// One decoded instruction is taken per clock cycle while req_stall is low. At acceptance the register file
// and the data memory are read into registers; the execute stage then computes, writes
// back and loads the response register once that register can take the result, and a new
// request can follow every cycle unless a stalled response holds execute. Writes of the instruction in
// execute are forwarded to the reads of the next one. After reset the data memory
// written flags are cleared in a sweep, during which req_stall is high; configuration
// writes are always taken.
`default_nettype none
module risc_subset_executor_dram_timing_top #(
   parameter int MEM_WORDS = 262144
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_action,
   input  wire logic [15:0]        req_line_index,
   input  wire logic [5:0]         req_dest_reg,
   input  wire logic [5:0]         req_src_a_reg,
   input  wire logic [5:0]         req_src_b_reg,
   input  wire logic signed [31:0] req_immediate,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [15:0]             rsp_next_line,
   output logic                    rsp_reg_write,
   output logic [4:0]              rsp_written_reg,
   output logic signed [31:0]      rsp_written_value,
   output logic [31:0]             rsp_cycle_total,
   output logic [31:0]             rsp_row_activations,
   output logic [11:0]             rsp_overlap_credit,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   localparam int AW = $clog2(MEM_WORDS);

   logic [9:0]             row_delay_ff, col_delay_ff;
   logic                   accept;
   logic                   dm_clearing;
   logic [5:0]             rd0_addr, rd1_addr;
   logic [31:0]            op0, op1;
   logic                   mem_valid;
   logic [31:0]            mem_data;
   rsde_pkg::rf_wr_type    rf_wr;
   rsde_pkg::exec_ctl_type ctl;
   logic                   dm_wr_en;
   logic [AW-1:0]          dm_wr_idx;
   logic [31:0]            dm_wr_data;
   logic                   cmp_op;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_delay_ff <= rsde_pkg::ROW_DELAY_RESET;
         col_delay_ff <= rsde_pkg::COL_DELAY_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rsde_pkg::CSR_ROW_DELAY: row_delay_ff <= csr_data[9:0];
            rsde_pkg::CSR_COL_DELAY: col_delay_ff <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = dm_clearing || ctl.hold;
   assign accept    = req_valid && !req_stall;

   assign cmp_op   = (req_action == rsde_pkg::ACT_BEQ) || (req_action == rsde_pkg::ACT_BNE);
   assign rd0_addr = (cmp_op || (req_action == rsde_pkg::ACT_SW)) ? req_dest_reg : req_src_a_reg;
   assign rd1_addr = cmp_op ? req_src_a_reg : req_src_b_reg;

   rsde_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd0_addr (rd0_addr),
      .rd1_addr (rd1_addr),
      .wr       (rf_wr),
      .rd0_data (op0),
      .rd1_data (op1)
   );

   rsde_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx   (req_immediate[AW+1:2]),
      .wr_en    (dm_wr_en),
      .wr_idx   (dm_wr_idx),
      .wr_data  (dm_wr_data),
      .rd_valid (mem_valid),
      .rd_data  (mem_data),
      .clearing (dm_clearing)
   );

   rsde_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .action              (req_action),
      .line_index          (req_line_index),
      .dest_reg            (req_dest_reg),
      .src_a_reg           (req_src_a_reg),
      .src_b_reg           (req_src_b_reg),
      .immediate           (req_immediate),
      .op0                 (op0),
      .op1                 (op1),
      .mem_valid           (mem_valid),
      .mem_data            (mem_data),
      .row_delay           (row_delay_ff),
      .col_delay           (col_delay_ff),
      .out_stall           (rsp_stall),
      .ctl                 (ctl),
      .rf_wr               (rf_wr),
      .dm_wr_en            (dm_wr_en),
      .dm_wr_idx           (dm_wr_idx),
      .dm_wr_data          (dm_wr_data),
      .out_valid           (rsp_valid),
      .out_status          (rsp_status),
      .out_next_line       (rsp_next_line),
      .out_reg_write       (rsp_reg_write),
      .out_written_reg     (rsp_written_reg),
      .out_written_value   (rsp_written_value),
      .out_cycle_total     (rsp_cycle_total),
      .out_row_activations (rsp_row_activations),
      .out_overlap_credit  (rsp_overlap_credit)
   );

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> ctl.s1_valid)
      else $error("accepted transaction did not reach execute");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      dm_clearing |-> !accept)
      else $error("transaction accepted during memory clear");

   a_fail_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != rsde_pkg::ST_OK)) |->
         (!rsp_reg_write && (rsp_written_value == 32'sd0)))
      else $error("failing transaction reports a write");

   a_wr_only_idle_exec: assert property (@(posedge clock) disable iff (reset)
      (rf_wr.en || dm_wr_en) |-> ctl.s1_valid)
      else $error("write without a transaction in execute");
endmodule
`default_nettype wire

/* src/rsde_regfile.sv */
// Register file: 32 words, two registered read ports, one write port.
// Reset-to-zero via per-entry valid bits; write-to-read forwarding. Uses rsde_pkg.
`default_nettype none
module rsde_regfile (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [5:0]          rd0_addr,
   input  wire logic [5:0]          rd1_addr,
   input  wire rsde_pkg::rf_wr_type wr,
   output logic [31:0]              rd0_data,
   output logic [31:0]              rd1_data
);
   logic [31:0] mem [32];
   logic [31:0] valid_ff;
   logic [31:0] q0_ff, q1_ff, byp_ff;
   logic        zero0_ff, zero1_ff, fwd0_ff, fwd1_ff;
   logic        zero0_in, zero1_in, fwd0_in, fwd1_in;

   assign zero0_in = rd0_addr[5] || !valid_ff[rd0_addr[4:0]];
   assign zero1_in = rd1_addr[5] || !valid_ff[rd1_addr[4:0]];
   assign fwd0_in  = wr.en && !rd0_addr[5] && (wr.idx == rd0_addr[4:0]);
   assign fwd1_in  = wr.en && !rd1_addr[5] && (wr.idx == rd1_addr[4:0]);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         q0_ff    <= mem[rd0_addr[4:0]];
         q1_ff    <= mem[rd1_addr[4:0]];
         zero0_ff <= zero0_in;
         zero1_ff <= zero1_in;
         fwd0_ff  <= fwd0_in;
         fwd1_ff  <= fwd1_in;
         byp_ff   <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   assign rd0_data = fwd0_ff ? byp_ff : (zero0_ff ? 32'd0 : q0_ff);
   assign rd1_data = fwd1_ff ? byp_ff : (zero1_ff ? 32'd0 : q1_ff);
endmodule
`default_nettype wire

/* src/rsde_dmem.sv */
// Data memory: one word plus a written flag per entry, one read and one write port.
// Clears the written flags in a sweep after reset; forwards a same-cycle write.
`default_nettype none
module rsde_dmem #(
   parameter int MEM_WORDS = 262144
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(MEM_WORDS)-1:0] rd_idx,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MEM_WORDS)-1:0] wr_idx,
   input  wire logic [31:0]                  wr_data,
   output logic                              rd_valid,
   output logic [31:0]                       rd_data,
   output logic                              clearing
);
   localparam int AW = $clog2(MEM_WORDS);

   logic [32:0]   mem [MEM_WORDS];
   logic [32:0]   q_ff;
   logic [31:0]   byp_ff;
   logic          fwd_ff;
   logic          clr_ff;
   logic [AW-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_idx] <= {1'b1, wr_data};
      end
      if (rd_en) begin
         q_ff   <= mem[rd_idx];
         fwd_ff <= wr_en && (wr_idx == rd_idx);
         byp_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(MEM_WORDS - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   assign rd_valid = fwd_ff || q_ff[32];
   assign rd_data  = fwd_ff ? byp_ff : q_ff[31:0];
   assign clearing = clr_ff;
endmodule
`default_nettype wire

/* src/rsde_exec.sv */
// Execute stage: holds the item whose operands were read, computes result and status,
// updates DRAM timing state, writes back and loads the response register. Uses rsde_pkg.
`default_nettype none
module rsde_exec #(
   parameter int MEM_WORDS = 262144
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [3:0]                   action,
   input  wire logic [15:0]                  line_index,
   input  wire logic [5:0]                   dest_reg,
   input  wire logic [5:0]                   src_a_reg,
   input  wire logic [5:0]                   src_b_reg,
   input  wire logic signed [31:0]           immediate,
   input  wire logic [31:0]                  op0,
   input  wire logic [31:0]                  op1,
   input  wire logic                         mem_valid,
   input  wire logic [31:0]                  mem_data,
   input  wire logic [9:0]                   row_delay,
   input  wire logic [9:0]                   col_delay,
   input  wire logic                         out_stall,
   output rsde_pkg::exec_ctl_type            ctl,
   output rsde_pkg::rf_wr_type               rf_wr,
   output logic                              dm_wr_en,
   output logic [$clog2(MEM_WORDS)-1:0]      dm_wr_idx,
   output logic [31:0]                       dm_wr_data,
   output logic                              out_valid,
   output logic [2:0]                        out_status,
   output logic [15:0]                       out_next_line,
   output logic                              out_reg_write,
   output logic [4:0]                        out_written_reg,
   output logic signed [31:0]                out_written_value,
   output logic [31:0]                       out_cycle_total,
   output logic [31:0]                       out_row_activations,
   output logic [11:0]                       out_overlap_credit
);
   localparam int AW    = $clog2(MEM_WORDS);
   localparam int BA    = AW + 2;
   localparam int ROW_W = BA - rsde_pkg::ROW_SHIFT;
   localparam int LIMIT = MEM_WORDS * 4;

   logic                s1_valid_ff;
   logic [3:0]          act_ff;
   logic [15:0]         line_ff;
   logic [5:0]          d_ff, a_ff, b_ff;
   logic signed [31:0]  imm_ff;

   logic [11:0]         save_ff, save_in;
   logic [31:0]         clk_ff, clk_in;
   logic [31:0]         actv_ff, actv_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                row_open_ff, row_open_in;
   logic [5:0]          busy_ff, busy_in;

   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [15:0]         rsp_next_ff;
   logic                rsp_wr_ff;
   logic [4:0]          rsp_wreg_ff;
   logic [31:0]         rsp_wval_ff;

   logic                fire;
   logic [2:0]          status;
   logic [15:0]         next;
   logic                have;
   logic [31:0]         result, wval;
   logic                in_range, aligned, tgt_ok, eq, taken;
   logic                bd, ba, bb, hit;
   logic [32:0]         sum33;
   logic [31:0]         prod;
   logic [ROW_W-1:0]    row;
   logic [11:0]         cost;
   logic                do_wr;

   assign fire = s1_valid_ff && (!rsp_valid_ff || !out_stall);

   assign in_range = (imm_ff >= 0) && (imm_ff < LIMIT);
   assign aligned  = (imm_ff[1:0] == 2'b00);
   assign tgt_ok   = (imm_ff >= 1) && (imm_ff <= rsde_pkg::LINE_LIMIT);
   assign eq       = (op0 == op1);
   assign bd       = !d_ff[5] && (d_ff == busy_ff);
   assign ba       = !a_ff[5] && (a_ff == busy_ff);
   assign bb       = !b_ff[5] && (b_ff == busy_ff);
   assign prod     = op0 * op1;
   assign row      = imm_ff[BA-1:rsde_pkg::ROW_SHIFT];

   always_comb begin
      status      = rsde_pkg::ST_OK;
      next        = line_ff + 16'd1;
      have        = 1'b0;
      result      = '0;
      wval        = '0;
      taken       = 1'b0;
      hit         = 1'b0;
      sum33       = '0;
      cost        = '0;
      save_in     = save_ff;
      clk_in      = clk_ff;
      actv_in     = actv_ff;
      row_in      = row_ff;
      row_open_in = row_open_ff;
      busy_in     = busy_ff;
      if (!row_open_ff) begin
         cost = 12'(row_delay) + 12'(col_delay);
      end else if (row_ff == row) begin
         cost = 12'(col_delay);
      end else begin
         cost = 12'({row_delay, 1'b0}) + 12'(col_delay);
      end
      unique case (act_ff)
         rsde_pkg::ACT_ADD, rsde_pkg::ACT_SUB: begin
            sum33 = (act_ff == rsde_pkg::ACT_ADD) ?
                    {op0[31], op0} + {op1[31], op1} : {op0[31], op0} - {op1[31], op1};
            if ((sum33[32] != sum33[31]) || (sum33 == 33'h1_8000_0000)) begin
               status = rsde_pkg::ST_WORD_LIM;
            end else begin
               result = sum33[31:0];
               have   = 1'b1;
               hit    = bd || ba || bb;
            end
         end
         rsde_pkg::ACT_ADDI: begin
            result = op0 + imm_ff;
            have   = 1'b1;
            hit    = bd || ba;
         end
         rsde_pkg::ACT_MUL: begin
            result = prod;
            have   = 1'b1;
            hit    = bd || ba || bb;
         end
         rsde_pkg::ACT_J: begin
            if (!tgt_ok) begin
               status = rsde_pkg::ST_BAD_TGT;
            end else begin
               next   = imm_ff[15:0] - 16'd1;
               clk_in = clk_ff + 32'd1;
               if (save_ff != 12'd0) begin
                  save_in = save_ff - 12'd1;
               end
            end
         end
         rsde_pkg::ACT_BEQ, rsde_pkg::ACT_BNE: begin
            taken = (act_ff == rsde_pkg::ACT_BEQ) ? eq : !eq;
            hit   = bd || ba;
            if (taken && !tgt_ok) begin
               status = rsde_pkg::ST_BAD_TGT;
            end else if (taken) begin
               next = imm_ff[15:0] - 16'd1;
            end
         end
         rsde_pkg::ACT_SLT: begin
            result = ($signed(op0) < $signed(op1)) ? 32'd1 : 32'd0;
            have   = 1'b1;
            clk_in = clk_ff + 32'd1;
         end
         rsde_pkg::ACT_LW: begin
            if (!in_range || !mem_valid) begin
               status = rsde_pkg::ST_UNWRITTEN;
            end else if (!aligned) begin
               status = rsde_pkg::ST_MISALIGN;
            end else begin
               result  = mem_data;
               have    = 1'b1;
               busy_in = d_ff[5] ? rsde_pkg::NO_REG : d_ff;
            end
         end
         rsde_pkg::ACT_SW: begin
            if (!in_range) begin
               status = rsde_pkg::ST_MEM_OVF;
            end else if (!aligned) begin
               status = rsde_pkg::ST_MISALIGN;
            end else begin
               wval = op0;
            end
         end
         default: begin
         end
      endcase
      if (status == rsde_pkg::ST_OK) begin
         if ((act_ff == rsde_pkg::ACT_ADD) || (act_ff == rsde_pkg::ACT_SUB) ||
             (act_ff == rsde_pkg::ACT_ADDI) || (act_ff == rsde_pkg::ACT_MUL) ||
             (act_ff == rsde_pkg::ACT_BEQ) || (act_ff == rsde_pkg::ACT_BNE)) begin
            if ((save_ff != 12'd0) && !hit) begin
               save_in = save_ff - 12'd1;
            end else begin
               clk_in  = clk_ff + 32'd1;
               save_in = '0;
            end
         end
         if ((act_ff == rsde_pkg::ACT_LW) || (act_ff == rsde_pkg::ACT_SW)) begin
            clk_in      = clk_ff + 32'(cost) + 32'd1;
            save_in     = cost;
            row_in      = row;
            row_open_in = 1'b1;
            if (!row_open_ff || (row_ff != row)) begin
               actv_in = actv_ff + 32'd1;
            end
         end
      end else begin
         next = line_ff;
      end
   end

   assign do_wr = (status == rsde_pkg::ST_OK) && have && !d_ff[5];

   assign rf_wr.en    = fire && do_wr;
   assign rf_wr.idx   = d_ff[4:0];
   assign rf_wr.data  = result;
   assign dm_wr_en    = fire && (status == rsde_pkg::ST_OK) && (act_ff == rsde_pkg::ACT_SW);
   assign dm_wr_idx   = imm_ff[AW+1:2];
   assign dm_wr_data  = op0;

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= action;
         line_ff <= line_index;
         d_ff    <= dest_reg;
         a_ff    <= src_a_reg;
         b_ff    <= src_b_reg;
         imm_ff  <= immediate;
      end
      if (fire) begin
         rsp_status_ff <= status;
         rsp_next_ff   <= next;
         rsp_wr_ff     <= do_wr;
         rsp_wreg_ff   <= do_wr ? d_ff[4:0] : 5'd0;
         rsp_wval_ff   <= do_wr ? result : wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         save_ff      <= '0;
         clk_ff       <= '0;
         actv_ff      <= '0;
         row_ff       <= '0;
         row_open_ff  <= 1'b0;
         busy_ff      <= rsde_pkg::NO_REG;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            save_ff      <= save_in;
            clk_ff       <= clk_in;
            actv_ff      <= actv_in;
            row_ff       <= row_in;
            row_open_ff  <= row_open_in;
            busy_ff      <= busy_in;
         end else if (!out_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign ctl.s1_valid = s1_valid_ff;
   assign ctl.hold     = s1_valid_ff && !fire;

   assign out_valid           = rsp_valid_ff;
   assign out_status          = rsp_status_ff;
   assign out_next_line       = rsp_next_ff;
   assign out_reg_write       = rsp_wr_ff;
   assign out_written_reg     = rsp_wreg_ff;
   assign out_written_value   = rsp_wval_ff;
   assign out_cycle_total     = clk_ff;
   assign out_row_activations = actv_ff;
   assign out_overlap_credit  = save_ff;
endmodule
`default_nettype wire

/* test/rsde_result_checker.sv */
// Result checker for the instruction executor with DRAM row-buffer timing.
// Tracks CSR writes and requests, predicts each response and compares; uses rsde_pkg.
`default_nettype none
module rsde_result_checker #(
   parameter int MEM_WORDS = 262144
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [3:0]         req_action,
   input  wire logic [15:0]        req_line_index,
   input  wire logic [5:0]         req_dest_reg,
   input  wire logic [5:0]         req_src_a_reg,
   input  wire logic [5:0]         req_src_b_reg,
   input  wire logic signed [31:0] req_immediate,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [2:0]         rsp_status,
   input  wire logic [15:0]        rsp_next_line,
   input  wire logic               rsp_reg_write,
   input  wire logic [4:0]         rsp_written_reg,
   input  wire logic signed [31:0] rsp_written_value,
   input  wire logic [31:0]        rsp_cycle_total,
   input  wire logic [31:0]        rsp_row_activations,
   input  wire logic [11:0]        rsp_overlap_credit,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   output int                      mismatches,
   output int                      pending,
   output int                      responses_checked
);
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] next_line;
      logic        reg_write;
      logic [4:0]  written_reg;
      logic [31:0] written_value;
      logic [31:0] cycle_total;
      logic [31:0] row_activations;
      logic [11:0] overlap_credit;
   } exec_result_type;

   localparam longint MEM_BYTES = longint'(MEM_WORDS) * 4;
   localparam longint WORD_MAX = 64'sd2147483647;

   exec_result_type expected_results[$];

   logic [9:0]  row_delay, col_delay;
   logic [31:0] regs [32];
   logic [31:0] dram_words [int];
   int          open_row;
   bit          row_open;
   logic [5:0]  busy_reg;
   logic [11:0] credit;
   logic [31:0] cycles, activations;

   function automatic logic [31:0] reg_value(logic [5:0] r);
      return r < 32 ? regs[r[4:0]] : 32'd0;
   endfunction

   function automatic bit is_busy(logic [5:0] r);
      return r < 32 && r == busy_reg;
   endfunction

   task automatic alu_timing(bit hit);
      if (credit > 0 && !hit) begin
         credit--;
      end else begin
         cycles++;
         credit = '0;
      end
   endtask

   task automatic dram_timing(int row);
      logic [31:0] cost;
      if (!row_open) begin
         cost = row_delay + col_delay;
         activations++;
      end else if (open_row == row) begin
         cost = col_delay;
      end else begin
         cost = 2 * row_delay + col_delay;
         activations++;
      end
      open_row = row;
      row_open = 1;
      cycles += cost;
      credit = cost[11:0];
   endtask

   task automatic execute_instruction(output exec_result_type res);
      longint      imm, x, y, sum;
      logic [2:0]  status;
      logic [15:0] next;
      logic [31:0] value, stored;
      bit          have, taken;
      logic [5:0]  d, a, b;
      imm = longint'(req_immediate);
      d = req_dest_reg;
      a = req_src_a_reg;
      b = req_src_b_reg;
      status = rsde_pkg::ST_OK;
      next = req_line_index + 16'd1;
      value = '0;
      stored = '0;
      have = 0;
      case (req_action)
         rsde_pkg::ACT_ADD, rsde_pkg::ACT_SUB: begin
            x = longint'($signed(reg_value(a)));
            y = longint'($signed(reg_value(b)));
            sum = (req_action == rsde_pkg::ACT_ADD) ? x + y : x - y;
            if (sum > WORD_MAX || sum < -WORD_MAX) begin
               status = rsde_pkg::ST_WORD_LIM;
            end else begin
               value = sum[31:0];
               have = 1;
               alu_timing(is_busy(d) || is_busy(a) || is_busy(b));
            end
         end
         rsde_pkg::ACT_ADDI: begin
            value = reg_value(a) + imm[31:0];
            have = 1;
            alu_timing(is_busy(d) || is_busy(a));
         end
         rsde_pkg::ACT_MUL: begin
            value = reg_value(a) * reg_value(b);
            have = 1;
            alu_timing(is_busy(d) || is_busy(a) || is_busy(b));
         end
         rsde_pkg::ACT_J: begin
            if (imm < 1 || imm > rsde_pkg::LINE_LIMIT) begin
               status = rsde_pkg::ST_BAD_TGT;
            end else begin
               next = imm[15:0] - 16'd1;
               cycles++;
               if (credit > 0) credit--;
            end
         end
         rsde_pkg::ACT_BEQ, rsde_pkg::ACT_BNE: begin
            taken = (reg_value(d) == reg_value(a)) == (req_action == rsde_pkg::ACT_BEQ);
            if (taken && (imm < 1 || imm > rsde_pkg::LINE_LIMIT)) begin
               status = rsde_pkg::ST_BAD_TGT;
            end else begin
               if (taken) next = imm[15:0] - 16'd1;
               alu_timing(is_busy(d) || is_busy(a));
            end
         end
         rsde_pkg::ACT_SLT: begin
            value = ($signed(reg_value(a)) < $signed(reg_value(b))) ? 32'd1 : 32'd0;
            have = 1;
            cycles++;
         end
         rsde_pkg::ACT_LW: begin
            if (imm < 0 || imm >= MEM_BYTES || !dram_words.exists(int'(imm >>> 2))) begin
               status = rsde_pkg::ST_UNWRITTEN;
            end else if (imm[1:0] != 0) begin
               status = rsde_pkg::ST_MISALIGN;
            end else begin
               value = dram_words[int'(imm >>> 2)];
               have = 1;
               busy_reg = d < 32 ? d : rsde_pkg::NO_REG;
               cycles++;
               dram_timing(int'(imm / rsde_pkg::ROW_BYTES));
            end
         end
         rsde_pkg::ACT_SW: begin
            if (imm < 0 || imm >= MEM_BYTES) begin
               status = rsde_pkg::ST_MEM_OVF;
            end else if (imm[1:0] != 0) begin
               status = rsde_pkg::ST_MISALIGN;
            end else begin
               stored = reg_value(d);
               dram_words[int'(imm >>> 2)] = stored;
               cycles++;
               dram_timing(int'(imm / rsde_pkg::ROW_BYTES));
            end
         end
         default: ;
      endcase
      res = '0;
      res.status = status;
      if (status != rsde_pkg::ST_OK) begin
         res.next_line = req_line_index;
      end else begin
         res.next_line = next;
         res.written_value = stored;
         if (have && d < 32) begin
            regs[d[4:0]] = value;
            res.reg_write = 1;
            res.written_reg = d[4:0];
            res.written_value = value;
         end
      end
      res.cycle_total = cycles;
      res.row_activations = activations;
      res.overlap_credit = credit;
   endtask

   always @(posedge clock) begin
      exec_result_type want, got;
      if (reset) begin
         row_delay = rsde_pkg::ROW_DELAY_RESET;
         col_delay = rsde_pkg::COL_DELAY_RESET;
         foreach (regs[i]) regs[i] = '0;
         dram_words.delete();
         open_row = 0;
         row_open = 0;
         busy_reg = rsde_pkg::NO_REG;
         credit = '0;
         cycles = '0;
         activations = '0;
         expected_results.delete();
         mismatches = 0;
         responses_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == rsde_pkg::CSR_ROW_DELAY) row_delay = csr_data[9:0];
            else if (csr_index == rsde_pkg::CSR_COL_DELAY) col_delay = csr_data[9:0];
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_next_line, rsp_reg_write, rsp_written_reg,
                   rsp_written_value, rsp_cycle_total, rsp_row_activations,
                   rsp_overlap_credit};
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected response transaction, status %0d", rsp_status);
            end else begin
               want = expected_results.pop_front();
               responses_checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: response %0d mismatch", responses_checked);
                     $display("  exp st=%0d nl=%0d wr=%0d reg=%0d val=%h cyc=%0d act=%0d cr=%0d",
                              want.status, want.next_line, want.reg_write, want.written_reg,
                              want.written_value, want.cycle_total, want.row_activations,
                              want.overlap_credit);
                     $display("  got st=%0d nl=%0d wr=%0d reg=%0d val=%h cyc=%0d act=%0d cr=%0d",
                              got.status, got.next_line, got.reg_write, got.written_reg,
                              got.written_value, got.cycle_total, got.row_activations,
                              got.overlap_credit);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            execute_instruction(want);
            expected_results = {expected_results, want};
         end
      end
      pending = expected_results.size();
   end

endmodule
`default_nettype wire

/* test/tb_risc_subset_executor_dram_timing_top.sv */
// Testbench top for the instruction executor with DRAM row-buffer timing.
// Drives instructions and CSR writes; checking is in rsde_result_checker; uses rsde_pkg.
`default_nettype none
module tb_risc_subset_executor_dram_timing_top;
   localparam int MEM_WORDS = 262144;
   localparam int MEM_BYTES = MEM_WORDS * 4;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [3:0]         req_action = '0;
   logic [15:0]        req_line_index = '0;
   logic [5:0]         req_dest_reg = '0;
   logic [5:0]         req_src_a_reg = '0;
   logic [5:0]         req_src_b_reg = '0;
   logic signed [31:0] req_immediate = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [2:0]         rsp_status;
   logic [15:0]        rsp_next_line;
   logic               rsp_reg_write;
   logic [4:0]         rsp_written_reg;
   logic signed [31:0] rsp_written_value;
   logic [31:0]        rsp_cycle_total;
   logic [31:0]        rsp_row_activations;
   logic [11:0]        rsp_overlap_credit;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   int mismatches, pending, responses_checked;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_age = 0;
   int sent = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   risc_subset_executor_dram_timing_top #(.MEM_WORDS(MEM_WORDS)) u_dut (.*);

   rsde_result_checker #(.MEM_WORDS(MEM_WORDS)) u_checker (.*);

   // receiver back-pressure: none, light or heavy, switching every so often
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_age <= $urandom_range(20, 120);
      end else begin
         stall_age <= stall_age - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 4) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   task automatic send_instr(logic [3:0] act, logic [15:0] line, logic [5:0] d,
                             logic [5:0] a, logic [5:0] b, logic [31:0] imm);
      req_valid <= 1'b1;
      req_action <= act;
      req_line_index <= line;
      req_dest_reg <= d;
      req_src_a_reg <= a;
      req_src_b_reg <= b;
      req_immediate <= imm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [5:0] pick_reg();
      int r;
      r = $urandom_range(0, 15);
      if (r < 9) return 6'($urandom_range(0, 5));
      if (r < 12) return 6'd32;
      if (r < 14) return 6'($urandom_range(0, 31));
      return 6'($urandom);
   endfunction

   function automatic logic [31:0] pick_addr();
      int r;
      r = $urandom_range(0, 19);
      if (r < 13) return 32'($urandom_range(0, 2) * 1024 + $urandom_range(0, 3) * 4
                         + (r == 0 ? 2048 * 100 : 0));
      if (r == 13) return 32'(MEM_BYTES - 4);
      if (r == 14) return 32'(MEM_BYTES);
      if (r == 15) return 32'($urandom_range(1, 8) * -4);
      if (r == 16) return 32'($urandom_range(0, 4095));
      if (r == 17) return 32'($urandom_range(0, MEM_BYTES - 1)) & ~32'd3;
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_target();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 32'($urandom_range(1, 65536));
      if (r == 6) return 32'd0;
      if (r == 7) return 32'd65537;
      if (r == 8) return 32'd65536;
      return $urandom;
   endfunction

   task automatic random_instr();
      logic [3:0]  act;
      logic [31:0] imm;
      int          r;
      r = $urandom_range(0, 31);
      act = (r == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      case (act)
         rsde_pkg::ACT_ADDI:
            imm = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 200) - 100);
         rsde_pkg::ACT_J, rsde_pkg::ACT_BEQ, rsde_pkg::ACT_BNE: imm = pick_target();
         rsde_pkg::ACT_LW, rsde_pkg::ACT_SW: imm = pick_addr();
         default: imm = $urandom;
      endcase
      send_instr(act, 16'($urandom), pick_reg(), pick_reg(), pick_reg(), imm);
   endtask

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset timing values
      send_instr(rsde_pkg::ACT_ADDI, 16'd0, 6'd1, 6'd32, 6'd0, 32'h7fffffff);
      send_instr(rsde_pkg::ACT_ADDI, 16'd1, 6'd2, 6'd1, 6'd0, 32'h00000001);
      send_instr(rsde_pkg::ACT_ADD, 16'd2, 6'd3, 6'd1, 6'd1, 32'd0);
      send_instr(rsde_pkg::ACT_SUB, 16'd3, 6'd3, 6'd32, 6'd2, 32'd0);
      send_instr(rsde_pkg::ACT_SUB, 16'd4, 6'd3, 6'd32, 6'd1, 32'd0);
      send_instr(rsde_pkg::ACT_MUL, 16'd5, 6'd4, 6'd1, 6'd1, 32'd0);
      send_instr(rsde_pkg::ACT_SLT, 16'd6, 6'd5, 6'd2, 6'd1, 32'd0);
      send_instr(rsde_pkg::ACT_SW, 16'd7, 6'd1, 6'd0, 6'd0, 32'(MEM_BYTES - 4));
      send_instr(rsde_pkg::ACT_LW, 16'd8, 6'd6, 6'd0, 6'd0, 32'(MEM_BYTES - 4));
      send_instr(rsde_pkg::ACT_ADD, 16'd9, 6'd7, 6'd6, 6'd32, 32'd0);
      send_instr(rsde_pkg::ACT_LW, 16'd10, 6'd7, 6'd0, 6'd0, 32'(MEM_BYTES - 3));
      send_instr(rsde_pkg::ACT_LW, 16'd11, 6'd7, 6'd0, 6'd0, 32'd0);
      send_instr(rsde_pkg::ACT_LW, 16'd12, 6'd7, 6'd0, 6'd0, 32'hffffffff);
      send_instr(rsde_pkg::ACT_SW, 16'd13, 6'd2, 6'd0, 6'd0, 32'(MEM_BYTES));
      send_instr(rsde_pkg::ACT_SW, 16'd14, 6'd2, 6'd0, 6'd0, 32'hfffffffc);
      send_instr(rsde_pkg::ACT_SW, 16'd15, 6'd2, 6'd0, 6'd0, 32'd5);
      send_instr(rsde_pkg::ACT_SW, 16'd16, 6'd2, 6'd0, 6'd0, 32'd0);
      send_instr(rsde_pkg::ACT_LW, 16'd17, 6'd32, 6'd0, 6'd0, 32'd0);
      send_instr(rsde_pkg::ACT_J, 16'd18, 6'd0, 6'd0, 6'd0, 32'd0);
      send_instr(rsde_pkg::ACT_J, 16'd19, 6'd0, 6'd0, 6'd0, 32'd65536);
      send_instr(rsde_pkg::ACT_BEQ, 16'd20, 6'd32, 6'd32, 6'd0, 32'd65537);
      send_instr(rsde_pkg::ACT_BNE, 16'd21, 6'd32, 6'd32, 6'd0, 32'h80000000);
      send_instr(rsde_pkg::ACT_BNE, 16'd22, 6'd1, 6'd32, 6'd0, 32'd1);
      send_instr(4'd12, 16'd23, 6'd63, 6'd63, 6'd63, 32'd0);
      send_instr(rsde_pkg::ACT_ADDI, 16'd65535, 6'd0, 6'd0, 6'd0, 32'h80000000);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_csr(rsde_pkg::CSR_ROW_DELAY, 32'd0);
               write_csr(rsde_pkg::CSR_COL_DELAY, 32'd0);
            end
            1: begin
               write_csr(rsde_pkg::CSR_ROW_DELAY, 32'd1023);
               write_csr(rsde_pkg::CSR_COL_DELAY, 32'd1023);
            end
            2: begin
               write_csr(rsde_pkg::CSR_ROW_DELAY, 32'd1023);
               write_csr(rsde_pkg::CSR_COL_DELAY, 32'd0);
            end
            3: begin
               write_csr(rsde_pkg::CSR_ROW_DELAY, 32'hfffffc05);
               write_csr(rsde_pkg::CSR_COL_DELAY, $urandom);
            end
            default: begin
               write_csr(rsde_pkg::CSR_ROW_DELAY, 32'($urandom_range(0, 20)));
               write_csr(rsde_pkg::CSR_COL_DELAY, 32'($urandom_range(0, 5)));
            end
         endcase
         csr_valid <= 1'b0;
         repeat (105) random_instr();
         drain();
      end

      $display("Sent %0d instructions over six timing settings, %0d responses checked.",
               sent, responses_checked);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
